// ===== hw/rtl/latency_stats_with_topk_outliers_defines.svh =====
// assertion macros used by the checker file lso_chk
`ifndef LATENCY_STATS_WITH_TOPK_OUTLIERS_DEFINES_SVH
`define LATENCY_STATS_WITH_TOPK_OUTLIERS_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LSO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lso check failed");

// antecedent implies consequent in the next cycle
`define LSO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lso check failed");

`endif

// ===== hw/rtl/lso_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lso_pkg
// types and codes of the latency statistics block
// ----------------------------------------------------------------------------
package lso_pkg;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_SUM  = 2'd1;
    localparam logic [1:0] OP_SLOT = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam int         CFG_W     = 4;
    localparam logic [3:0] CAP_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  entity;
        logic [31:0] latency;
        logic [63:0] tag;
        logic [31:0] height;
        logic        which_list;
        logic [2:0]  slot;
    } lso_req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] sample_count;
        logic [31:0] min_latency;
        logic [31:0] mean_latency;
        logic [31:0] max_latency;
        logic [31:0] entry_time;
        logic [63:0] entry_tag;
        logic [31:0] entry_height;
        logic [3:0]  list_fill;
    } lso_rsp_t;

    typedef struct packed {
        logic [31:0] cnt;
        logic [31:0] lo;
        logic [31:0] mean;
        logic [31:0] hi;
    } lso_stat_t;

    typedef struct packed {
        logic [31:0] etime;
        logic [63:0] etag;
        logic [31:0] eheight;
    } lso_entry_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } lso_div_cmd_t;

endpackage

// ===== hw/rtl/lso_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lso_stream_if
// valid/ready channel carrying one payload item
// ----------------------------------------------------------------------------
interface lso_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lso_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lso_div
// unsigned 32-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lso_div
    import lso_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  lso_div_cmd_t cmd,
    output logic         done,
    output logic [31:0]  quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [32:0] shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        shifted   = {rem_reg, quo_reg[31]};
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            rem_next  = '0;
            quo_next  = cmd.dividend;
            dsr_next  = cmd.divisor;
        end
        else if (busy_reg)
        begin
            // the remainder stays below the divisor, so 32 bits hold it
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = 32'(shifted - {1'b0, dsr_reg});
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/latency_stats_with_topk_outliers.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_stats_with_topk_outliers
// per-entity latency min/mean/max with smallest and largest outlier lists
// ----------------------------------------------------------------------------
// channels: req (sink) takes one operation per item: add sample, read
// summary or read one outlier slot; rsp (source) returns one item per
// request; cfg (sink) writes the outlier list capacity, and the user must
// write it only while idle: the block itself does not enforce this.
// one item is worked on at a time; req.ready is high only when idle.
// a summary or slot read goes from the read state to the finish state,
// which loads the output register; a later add of an entity also runs the
// serial divider for the new mean, and an add then offers the sample to
// the smallest and the largest list in turn, where the insert walk moves
// one slot per compare and step state pair.
// the stats and outlier memories each have one read and one write port.
// reset clears valid bits and list fills and sets capacity to 8; the
// memories themselves are not cleared, valid bits and fill counts mask them.
// the result sits in an output register: a stalled receiver only holds
// the block once the next result is ready to be loaded.
// ----------------------------------------------------------------------------
module latency_stats_with_topk_outliers
    import lso_pkg::*;
#(
    parameter int NUM_ENTITIES = 16,
    parameter int MAX_OUTLIERS = 8
)(
    input  logic          clk,
    input  logic          rst_n,
    lso_stream_if.sink    cfg,
    lso_stream_if.sink    req,
    lso_stream_if.source  rsp
);

    localparam int EW        = (NUM_ENTITIES > 1) ? $clog2(NUM_ENTITIES) : 1;
    localparam int NUM_LISTS = 2 * NUM_ENTITIES;
    localparam int LW        = EW + 1;
    localparam int DEPTH     = NUM_LISTS * MAX_OUTLIERS;
    localparam int AW        = $clog2(DEPTH);
    localparam int FW        = $clog2(MAX_OUTLIERS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_WST  = 4'd3;
    localparam logic [3:0] S_OFF  = 4'd4;
    localparam logic [3:0] S_CMP  = 4'd5;
    localparam logic [3:0] S_STEP = 4'd6;
    localparam logic [3:0] S_REP  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    function automatic logic [AW-1:0] eaddr(input logic [LW-1:0] l, input logic [31:0] s);
        return AW'(32'(l) * MAX_OUTLIERS + s);
    endfunction

    function automatic logic more_ext(input logic [31:0] a, input logic [31:0] b,
                                      input logic largest);
        return largest ? (a > b) : (a < b);
    endfunction

    // control state
    logic [3:0]      state_reg, state_next;
    logic [CFG_W-1:0] cap_reg;
    logic            rsp_valid_reg, rsp_valid_next;
    logic            st_vld_reg [NUM_ENTITIES];
    logic [FW-1:0]   fill_reg [NUM_LISTS];

    // payload state
    lso_req_t        req_reg, req_next;
    logic [EW-1:0]   ent_reg, ent_next;
    logic            lsel_reg, lsel_next;
    logic [FW-1:0]   idx_reg, idx_next;
    logic            neg_reg, neg_next;
    lso_stat_t       work_reg, work_next;
    lso_rsp_t        rspw_reg, rspw_next;
    lso_rsp_t        rsp_data_reg;

    // memories
    lso_stat_t       stat_mem [NUM_ENTITIES];
    lso_entry_t      ent_mem [DEPTH];
    lso_stat_t       st_q;
    lso_entry_t      ent_q;

    logic            st_ren, st_we, st_vld_set;
    logic [EW-1:0]   st_raddr;
    logic            ent_ren, ent_we;
    logic [AW-1:0]   ent_raddr, ent_waddr;
    lso_entry_t      ent_wdata;
    logic            fill_we;
    logic [LW-1:0]   fill_widx;
    logic [FW-1:0]   fill_wval;
    logic            list_done, rsp_load;

    lso_div_cmd_t    div_cmd;
    logic            div_done;
    logic [31:0]     div_q;

    logic [FW-1:0]   cap_eff;
    logic [LW-1:0]   cur_lst;
    logic [FW-1:0]   cur_fill;
    logic [LW-1:0]   rd_lst;
    logic [FW-1:0]   rd_fill;
    logic [32:0]     diff;
    logic [31:0]     new_cnt;
    lso_entry_t      new_ent;

    lso_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cap_eff  = (32'(cap_reg) > MAX_OUTLIERS) ? FW'(MAX_OUTLIERS) : FW'(cap_reg);
    assign cur_lst  = {ent_reg, lsel_reg};
    assign cur_fill = fill_reg[cur_lst];
    assign rd_lst   = {ent_reg, req_reg.which_list};
    assign rd_fill  = fill_reg[rd_lst];
    assign new_ent  = '{etime: req_reg.latency, etag: req_reg.tag, eheight: req_reg.height};
    assign diff     = {1'b0, req_reg.latency} - {1'b0, st_q.mean};
    assign new_cnt  = (st_q.cnt == 32'hFFFF_FFFF) ? st_q.cnt : st_q.cnt + 32'd1;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        ent_next   = ent_reg;
        lsel_next  = lsel_reg;
        idx_next   = idx_reg;
        neg_next   = neg_reg;
        work_next  = work_reg;
        rspw_next  = rspw_reg;
        st_ren     = 1'b0;
        st_raddr   = ent_reg;
        st_we      = 1'b0;
        st_vld_set = 1'b0;
        ent_ren    = 1'b0;
        ent_raddr  = '0;
        ent_we     = 1'b0;
        ent_waddr  = '0;
        ent_wdata  = new_ent;
        fill_we    = 1'b0;
        fill_widx  = cur_lst;
        fill_wval  = FW'(cur_fill + 1'b1);
        list_done  = 1'b0;
        rsp_load   = 1'b0;
        div_cmd    = '{start: 1'b0, dividend: diff[32] ? 32'(-diff) : diff[31:0],
                       divisor: new_cnt};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next = req.data;
                    ent_next = EW'(req.data.entity);
                    if (32'(req.data.entity) >= NUM_ENTITIES || req.data.op == OP_NOP)
                    begin
                        rspw_next  = '0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        st_ren     = 1'b1;
                        st_raddr   = EW'(req.data.entity);
                        ent_ren    = 1'b1;
                        ent_raddr  = eaddr({EW'(req.data.entity), req.data.which_list},
                                           32'(req.data.slot));
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                rspw_next = '0;
                priority if (req_reg.op == OP_SUM)
                begin
                    if (st_vld_reg[ent_reg])
                    begin
                        rspw_next.found        = 1'b1;
                        rspw_next.sample_count = st_q.cnt;
                        rspw_next.min_latency  = st_q.lo;
                        rspw_next.mean_latency = st_q.mean;
                        rspw_next.max_latency  = st_q.hi;
                    end
                    state_next = S_FIN;
                end
                else if (req_reg.op == OP_SLOT)
                begin
                    rspw_next.list_fill = 4'(rd_fill);
                    if (32'(req_reg.slot) < 32'(rd_fill))
                    begin
                        rspw_next.found        = 1'b1;
                        rspw_next.entry_time   = ent_q.etime;
                        rspw_next.entry_tag    = ent_q.etag;
                        rspw_next.entry_height = ent_q.eheight;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    if (!st_vld_reg[ent_reg])
                    begin
                        work_next  = '{cnt: 32'd1, lo: req_reg.latency,
                                      mean: req_reg.latency, hi: req_reg.latency};
                        state_next = S_WST;
                    end
                    else
                    begin
                        work_next.cnt  = new_cnt;
                        work_next.lo   = (req_reg.latency < st_q.lo) ? req_reg.latency : st_q.lo;
                        work_next.hi   = (req_reg.latency > st_q.hi) ? req_reg.latency : st_q.hi;
                        work_next.mean = st_q.mean;
                        neg_next       = diff[32];
                        div_cmd.start  = 1'b1;
                        state_next     = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    work_next.mean = neg_reg ? work_reg.mean - div_q : work_reg.mean + div_q;
                    state_next     = S_WST;
                end
            end
            S_WST:
            begin
                st_we      = 1'b1;
                st_vld_set = 1'b1;
                lsel_next  = 1'b0;
                state_next = S_OFF;
            end
            S_OFF:
            begin
                if (cur_fill < cap_eff)
                begin
                    if (cur_fill == '0)
                    begin
                        ent_we    = 1'b1;
                        ent_waddr = eaddr(cur_lst, 32'd0);
                        fill_we   = 1'b1;
                        list_done = 1'b1;
                    end
                    else
                    begin
                        idx_next   = cur_fill;
                        ent_ren    = 1'b1;
                        ent_raddr  = eaddr(cur_lst, 32'(cur_fill - 1'b1));
                        state_next = S_CMP;
                    end
                end
                else if (cur_fill != '0)
                begin
                    ent_ren    = 1'b1;
                    ent_raddr  = eaddr(cur_lst, 32'd0);
                    state_next = S_REP;
                end
                else
                begin
                    list_done = 1'b1;
                end
            end
            S_CMP:
            begin
                ent_we    = 1'b1;
                ent_waddr = eaddr(cur_lst, 32'(idx_reg));
                if (more_ext(req_reg.latency, ent_q.etime, lsel_reg))
                begin
                    // shift the kept entry one slot down
                    ent_wdata  = ent_q;
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_STEP;
                end
                else
                begin
                    fill_we   = 1'b1;
                    list_done = 1'b1;
                end
            end
            S_STEP:
            begin
                if (idx_reg == '0)
                begin
                    ent_we    = 1'b1;
                    ent_waddr = eaddr(cur_lst, 32'd0);
                    fill_we   = 1'b1;
                    list_done = 1'b1;
                end
                else
                begin
                    ent_ren    = 1'b1;
                    ent_raddr  = eaddr(cur_lst, 32'(idx_reg - 1'b1));
                    state_next = S_CMP;
                end
            end
            S_REP:
            begin
                if (!more_ext(ent_q.etime, req_reg.latency, lsel_reg))
                begin
                    ent_we    = 1'b1;
                    ent_waddr = eaddr(cur_lst, 32'd0);
                end
                list_done = 1'b1;
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (list_done)
        begin
            if (!lsel_reg)
            begin
                lsel_next  = 1'b1;
                state_next = S_OFF;
            end
            else
            begin
                rspw_next              = '0;
                rspw_next.found        = 1'b1;
                rspw_next.sample_count = work_reg.cnt;
                rspw_next.min_latency  = work_reg.lo;
                rspw_next.mean_latency = work_reg.mean;
                rspw_next.max_latency  = work_reg.hi;
                state_next             = S_FIN;
            end
        end

        rsp_valid_next = rsp_load | (rsp_valid_reg & ~rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ENTITIES; i++)
            begin
                st_vld_reg[i] <= 1'b0;
            end
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid)
            begin
                cap_reg <= cfg.data;
            end
            if (st_vld_set)
            begin
                st_vld_reg[ent_reg] <= 1'b1;
            end
            if (fill_we)
            begin
                fill_reg[fill_widx] <= fill_wval;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        ent_reg  <= ent_next;
        lsel_reg <= lsel_next;
        idx_reg  <= idx_next;
        neg_reg  <= neg_next;
        work_reg <= work_next;
        rspw_reg <= rspw_next;
        if (rsp_load)
        begin
            rsp_data_reg <= rspw_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            stat_mem[ent_reg] <= work_reg;
        end
        if (st_ren)
        begin
            st_q <= stat_mem[st_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_ren)
        begin
            ent_q <= ent_mem[ent_raddr];
        end
    end

endmodule

// ===== hw/rtl/lso_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lso_chk
// port-level checks on the result channel of the statistics block
// ----------------------------------------------------------------------------
`include "latency_stats_with_topk_outliers_defines.svh"

module lso_chk
    import lso_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input lso_rsp_t rsp_data
);

    `LSO_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
    `LSO_ASSERT_NOW(a_miss_zero, clk, rst_n, rsp_valid && !rsp_data.found, rsp_data.sample_count == 32'd0 && rsp_data.min_latency == 32'd0 && rsp_data.entry_time == 32'd0 && rsp_data.entry_tag == 64'd0)
    `LSO_ASSERT_NOW(a_mean_order, clk, rst_n, rsp_valid && rsp_data.sample_count != 32'd0, rsp_data.min_latency <= rsp_data.mean_latency && rsp_data.mean_latency <= rsp_data.max_latency)
    `LSO_ASSERT_NOW(a_empty_list, clk, rst_n, rsp_valid && rsp_data.list_fill == 4'd0, rsp_data.entry_time == 32'd0 && rsp_data.entry_height == 32'd0)

endmodule

bind latency_stats_with_topk_outliers lso_chk u_lso_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
